[sv/adaptive_kalman_force_deadband_map_defines.svh]
// Assertion macros used by the checker file
`ifndef ADAPTIVE_KALMAN_FORCE_DEADBAND_MAP_DEFINES_SVH
`define ADAPTIVE_KALMAN_FORCE_DEADBAND_MAP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define AKFD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("akfd check failed");

// Next-cycle implication, sampled on clk, off during reset
`define AKFD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("akfd check failed");

`endif

[sv/akfd_pkg.sv]
package akfd_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_CMP,
        ST_PREP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_ME_GO,
        ST_ME_WAIT,
        ST_MP_GO,
        ST_MP_WAIT,
        ST_MT_GO,
        ST_MT_WAIT,
        ST_FINISH
    } akfd_state_t;

    localparam int MUL_STEPS = 32;
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = 66;

    localparam int NUM_AXES = 6;
    localparam int NUM_VEL  = 3;

    localparam logic [3:0] REG_FORCE_THR  = 4'd0;
    localparam logic [3:0] REG_TORQUE_THR = 4'd1;
    localparam logic [3:0] REG_FORCE_GAIN = 4'd2;
    localparam logic [3:0] REG_TORQUE_GAIN = 4'd3;
    localparam logic [3:0] REG_OFFSET_FX  = 4'd4;
    localparam logic [3:0] REG_SPEED_LIM  = 4'd5;
    localparam logic [3:0] REG_Q_MOVING   = 4'd6;
    localparam logic [3:0] REG_R_MOVING   = 4'd7;

endpackage

[sv/akfd_mul.sv]
module akfd_mul (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [akfd_pkg::MUL_A_W-1:0]    a,
    input  logic        [akfd_pkg::MUL_B_W-1:0]    b,
    output logic signed [akfd_pkg::MUL_P_W-1:0]    product,
    output logic                                   done
);

    localparam int CW = $clog2(akfd_pkg::MUL_STEPS);

    logic                                busy_reg;
    logic                                done_reg;
    logic [CW-1:0]                       cnt_reg;
    logic signed [akfd_pkg::MUL_P_W-1:0] acc_reg;
    logic signed [akfd_pkg::MUL_P_W-1:0] a_reg;
    logic        [akfd_pkg::MUL_B_W-1:0] b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(akfd_pkg::MUL_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one multiplier bit per cycle, lowest first
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= akfd_pkg::MUL_P_W'(a);
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
                acc_reg <= acc_reg + a_reg;
            a_reg <= a_reg <<< 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign product = acc_reg;
    assign done    = done_reg;

endmodule

[sv/akfd_div.sv]
module akfd_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [31:0]          num,
    input  logic [32:0]          den,
    output logic [FRAC_BITS:0]   quot,
    output logic                 done
);

    localparam int QBITS = FRAC_BITS + 1;
    localparam int CW    = $clog2(QBITS);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [33:0]       rem_reg;
    logic [32:0]       den_reg;
    logic [QBITS-1:0]  quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(QBITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle, highest first
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {2'b00, num};
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= {1'b0, den_reg})
            begin
                rem_reg  <= (rem_reg - {1'b0, den_reg}) << 1;
                quot_reg <= {quot_reg[QBITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_reg << 1;
                quot_reg <= {quot_reg[QBITS-2:0], 1'b0};
            end
        end
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

[sv/adaptive_kalman_force_deadband_map.sv]
// Force reflection stage: six scalar Kalman filters with speed-dependent
// noise, then a deadband and gain map, all in fixed point with FRAC_BITS
// fraction bits and saturated to 32 bits. The axes are remapped first
// (fx'=fy, fy'=-fx, fz'=fz, tx'=-tx, ty'=-ty, tz'=tz). One input transfer
// gives one output transfer. The block takes one sample at a time and
// works it through the shared bit-serial multiplier, 32 steps plus start
// and finish per product (three squares for the speed, three products per
// axis), and the bit-serial divider, FRAC_BITS + 1 steps per axis gain. A
// new sample is taken while a finished result still waits on the output.
// Registers must be written only while the block is idle; the block itself
// does not enforce this. Indexes beyond the list are ignored.
module adaptive_kalman_force_deadband_map #(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // force_x, force_y, force_z, torque_x, torque_y, torque_z, vel_x, vel_y, vel_z
    input  logic [287:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // target_fx, target_fy, target_fz, target_tx, target_ty, target_tz
    output logic [191:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic [3:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int QBITS = FRAC_BITS + 1;
    localparam logic [QBITS-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [30:0] ONE31  = 31'(1) << FRAC_BITS;
    localparam logic [30:0] HALF31 = 31'(1) << (FRAC_BITS - 1);
    localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > S32_MAX)
            return 32'sh7FFFFFFF;
        else if (v < S32_MIN)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [31:0] neg_sat(input logic signed [31:0] x);
        if (x == 32'sh80000000)
            return 32'sh7FFFFFFF;
        else
            return -x;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        if (x[31])
            return 32'(-x);
        else
            return x;
    endfunction

    akfd_pkg::akfd_state_t state_reg, state_next;

    logic [30:0]        force_thr_reg, torque_thr_reg, force_gain_reg, torque_gain_reg;
    logic signed [31:0] offset_fx_reg;
    logic [30:0]        speed_lim_reg, q_moving_reg, r_moving_reg;

    logic signed [31:0] est_reg [akfd_pkg::NUM_AXES];
    logic [30:0]        cov_reg [akfd_pkg::NUM_AXES];
    logic signed [31:0] meas_reg [akfd_pkg::NUM_AXES];
    logic signed [31:0] tgt_reg [akfd_pkg::NUM_AXES];
    logic [31:0]        vmag_reg [akfd_pkg::NUM_VEL];

    logic               out_valid_reg;
    logic [191:0]       out_data_reg;
    logic [63:0]        sp_reg;
    logic [1:0]         sq_reg;
    logic [2:0]         ax_reg;
    logic               moving_reg;
    logic [31:0]        pp_reg;
    logic               den_zero_reg;
    logic [QBITS-1:0]   k_reg;

    logic                 s_take;
    logic                 out_free;
    logic                 mul_start, div_start;
    logic signed [32:0]   mul_a;
    logic [31:0]          mul_b;
    logic signed [65:0]   mul_p;
    logic                 mul_done, div_done;
    logic [QBITS-1:0]     div_q;
    logic [32:0]          den;
    logic [30:0]          q_sel, r_sel;
    logic [63:0]          sp_lim;
    logic signed [65:0]   p_shift;
    logic [30:0]          thr_sel, gain_sel;
    logic signed [31:0]   off_sel;

    assign s_take   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign q_sel    = moving_reg ? q_moving_reg : ONE31;
    assign r_sel    = moving_reg ? r_moving_reg : HALF31;
    assign den      = {1'b0, pp_reg} + {2'b00, r_sel};
    assign sp_lim   = {33'd0, speed_lim_reg} << FRAC_BITS;
    assign p_shift  = mul_p >>> FRAC_BITS;
    assign thr_sel  = (ax_reg < 3'd3) ? force_thr_reg : torque_thr_reg;
    assign gain_sel = (ax_reg < 3'd3) ? force_gain_reg : torque_gain_reg;
    assign off_sel  = (ax_reg == 3'd0) ? offset_fx_reg : 32'sd0;

    akfd_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p),
        .done    (mul_done)
    );

    akfd_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (pp_reg),
        .den   (den),
        .quot  (div_q),
        .done  (div_done)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            akfd_pkg::ST_IDLE:
                if (s_take)
                    state_next = akfd_pkg::ST_SQ_GO;
            akfd_pkg::ST_SQ_GO:
                state_next = akfd_pkg::ST_SQ_WAIT;
            akfd_pkg::ST_SQ_WAIT:
                if (mul_done)
                    state_next = (sq_reg == 2'd2) ? akfd_pkg::ST_CMP : akfd_pkg::ST_SQ_GO;
            akfd_pkg::ST_CMP:
                state_next = akfd_pkg::ST_PREP;
            akfd_pkg::ST_PREP:
                state_next = akfd_pkg::ST_DIV_GO;
            akfd_pkg::ST_DIV_GO:
                state_next = akfd_pkg::ST_DIV_WAIT;
            akfd_pkg::ST_DIV_WAIT:
                if (div_done)
                    state_next = akfd_pkg::ST_ME_GO;
            akfd_pkg::ST_ME_GO:
                state_next = akfd_pkg::ST_ME_WAIT;
            akfd_pkg::ST_ME_WAIT:
                if (mul_done)
                    state_next = akfd_pkg::ST_MP_GO;
            akfd_pkg::ST_MP_GO:
                state_next = akfd_pkg::ST_MP_WAIT;
            akfd_pkg::ST_MP_WAIT:
                if (mul_done)
                    state_next = akfd_pkg::ST_MT_GO;
            akfd_pkg::ST_MT_GO:
                state_next = akfd_pkg::ST_MT_WAIT;
            akfd_pkg::ST_MT_WAIT:
                if (mul_done)
                    state_next = (ax_reg == 3'd5) ? akfd_pkg::ST_FINISH : akfd_pkg::ST_PREP;
            akfd_pkg::ST_FINISH:
                if (out_free)
                    state_next = akfd_pkg::ST_IDLE;
            default:
                state_next = akfd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == akfd_pkg::ST_IDLE);
        div_start     = (state_reg == akfd_pkg::ST_DIV_GO);
        mul_start     = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        unique case (state_reg)
            akfd_pkg::ST_SQ_GO:
            begin
                mul_start = 1'b1;
                mul_a     = {1'b0, vmag_reg[sq_reg]};
                mul_b     = vmag_reg[sq_reg];
            end
            akfd_pkg::ST_ME_GO:
            begin
                mul_start = 1'b1;
                mul_a     = 33'(meas_reg[ax_reg]) - 33'(est_reg[ax_reg]);
                mul_b     = 32'(k_reg);
            end
            akfd_pkg::ST_MP_GO:
            begin
                mul_start = 1'b1;
                mul_a     = {1'b0, pp_reg};
                mul_b     = 32'(ONE - k_reg);
            end
            akfd_pkg::ST_MT_GO:
            begin
                mul_start = 1'b1;
                mul_a     = 33'(est_reg[ax_reg]);
                mul_b     = {1'b0, gain_sel};
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= akfd_pkg::ST_IDLE;
            out_valid_reg   <= 1'b0;
            force_thr_reg   <= 31'd26214;
            torque_thr_reg  <= 31'd3277;
            force_gain_reg  <= 31'd3277;
            torque_gain_reg <= 31'd66;
            offset_fx_reg   <= 32'sd16384;
            speed_lim_reg   <= 31'd5898;
            q_moving_reg    <= 31'd52429;
            r_moving_reg    <= 31'd144179;
            for (int i = 0; i < akfd_pkg::NUM_AXES; i++)
            begin
                est_reg[i] <= '0;
                cov_reg[i] <= ONE31;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if ((state_reg == akfd_pkg::ST_FINISH) && out_free)
                out_valid_reg <= 1'b1;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    akfd_pkg::REG_FORCE_THR:   force_thr_reg   <= cfg_data[30:0];
                    akfd_pkg::REG_TORQUE_THR:  torque_thr_reg  <= cfg_data[30:0];
                    akfd_pkg::REG_FORCE_GAIN:  force_gain_reg  <= cfg_data[30:0];
                    akfd_pkg::REG_TORQUE_GAIN: torque_gain_reg <= cfg_data[30:0];
                    akfd_pkg::REG_OFFSET_FX:   offset_fx_reg   <= cfg_data;
                    akfd_pkg::REG_SPEED_LIM:   speed_lim_reg   <= cfg_data[30:0];
                    akfd_pkg::REG_Q_MOVING:    q_moving_reg    <= cfg_data[30:0];
                    akfd_pkg::REG_R_MOVING:    r_moving_reg    <= cfg_data[30:0];
                    default:                   offset_fx_reg   <= offset_fx_reg;
                endcase
            end

            if ((state_reg == akfd_pkg::ST_ME_WAIT) && mul_done)
                est_reg[ax_reg] <= sat32(66'(est_reg[ax_reg]) + p_shift);

            if ((state_reg == akfd_pkg::ST_MP_WAIT) && mul_done)
            begin
                if (p_shift > 66'sd2147483647)
                    cov_reg[ax_reg] <= 31'h7FFFFFFF;
                else
                    cov_reg[ax_reg] <= p_shift[30:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            meas_reg[0] <= s_axis_tdata[63:32];
            meas_reg[1] <= neg_sat(s_axis_tdata[31:0]);
            meas_reg[2] <= s_axis_tdata[95:64];
            meas_reg[3] <= neg_sat(s_axis_tdata[127:96]);
            meas_reg[4] <= neg_sat(s_axis_tdata[159:128]);
            meas_reg[5] <= s_axis_tdata[191:160];
            vmag_reg[0] <= mag32(s_axis_tdata[223:192]);
            vmag_reg[1] <= mag32(s_axis_tdata[255:224]);
            vmag_reg[2] <= mag32(s_axis_tdata[287:256]);
            sp_reg      <= '0;
            sq_reg      <= '0;
            ax_reg      <= '0;
        end

        if ((state_reg == akfd_pkg::ST_SQ_WAIT) && mul_done)
        begin
            sp_reg <= sp_reg + mul_p[63:0];
            sq_reg <= sq_reg + 2'd1;
        end

        if (state_reg == akfd_pkg::ST_CMP)
            moving_reg <= (sp_reg > sp_lim);

        if (state_reg == akfd_pkg::ST_PREP)
            pp_reg <= {1'b0, cov_reg[ax_reg]} + {1'b0, q_sel};

        if (state_reg == akfd_pkg::ST_DIV_GO)
            den_zero_reg <= (den == 33'd0);

        if ((state_reg == akfd_pkg::ST_DIV_WAIT) && div_done)
        begin
            if (den_zero_reg)
                k_reg <= '0;
            else if (div_q > ONE)
                k_reg <= ONE;
            else
                k_reg <= div_q;
        end

        if ((state_reg == akfd_pkg::ST_MT_WAIT) && mul_done)
        begin
            if ({1'b0, mag32(est_reg[ax_reg])} >= {2'b00, thr_sel})
                tgt_reg[ax_reg] <= sat32(66'(off_sel) + p_shift);
            else
                tgt_reg[ax_reg] <= off_sel;
            ax_reg <= ax_reg + 3'd1;
        end

        if ((state_reg == akfd_pkg::ST_FINISH) && out_free)
            out_data_reg <= {tgt_reg[5], tgt_reg[4], tgt_reg[3],
                             tgt_reg[2], tgt_reg[1], tgt_reg[0]};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[sv/akfd_checker.sv]
`include "adaptive_kalman_force_deadband_map_defines.svh"

module akfd_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [191:0] m_axis_tdata,
    input logic         cfg_we
);

    logic s_xfer;

    assign s_xfer = s_axis_tvalid && s_axis_tready;

    `AKFD_ASSERT_NXT(a_busy_after_transfer, s_xfer, !s_axis_tready)
    `AKFD_ASSERT_IMP(a_result_after_work, $rose(m_axis_tvalid), $past(!s_axis_tready))
    `AKFD_ASSERT_NXT(a_busy_no_new_result, s_xfer && !m_axis_tvalid, !m_axis_tvalid)
    `AKFD_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `AKFD_ASSERT_IMP(a_cfg_when_idle, cfg_we, s_axis_tready)

endmodule

bind adaptive_kalman_force_deadband_map akfd_checker u_akfd_checker (.*);
